// ===== design/ghsa_pkg.sv =====
// Shared types, codes and constants of the generational handle slot allocator.
`timescale 1ns / 1ps
`default_nettype none

package ghsa_pkg;

   // Default slot table depth
   localparam int SLOT_COUNT_DEFAULT = 256;

   // Occupancy and retirement bitmaps are kept in words of this many slots
   localparam int WORD_BITS  = 32;
   localparam int WORD_BIT_W = 5;

   // Field widths of the channels and registers
   localparam int KIND_W    = 2;
   localparam int BYTES_W   = 32;
   localparam int HANDLE_W  = 64;
   localparam int GEN_W     = 32;
   localparam int STATUS_W  = 3;
   localparam int LIVE_W    = 9;
   localparam int CSR_W     = 32;

   localparam logic [GEN_W-1:0]   GEN_MAX         = 32'hFFFF_FFFF;
   localparam logic [LIVE_W-1:0]  MAX_LIVE_RESET  = 9'd256;
   localparam logic [BYTES_W-1:0] MAX_BYTES_RESET = 32'hFFFF_FFFF;

   typedef enum logic [KIND_W-1:0] {
      KIND_ALLOC   = 2'd0,
      KIND_RELEASE = 2'd1,
      KIND_LOOKUP  = 2'd2,
      KIND_CLEAR   = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_LIVE      = 3'd1,
      STATUS_STORAGE   = 3'd2,
      STATUS_EXHAUSTED = 3'd3,
      STATUS_STALE     = 3'd4
   } status_type;

   typedef enum logic [0:0] {
      CSR_MAX_LIVE  = 1'b0,
      CSR_MAX_BYTES = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALLOC_CHECK,
      ST_SCAN_EVAL,
      ST_SLOT_WR,
      ST_LOOK_CHECK,
      ST_LOOK_WR,
      ST_CLEAR
   } state_type;

endpackage

`default_nettype wire

// ===== design/ghsa_req_if.sv =====
// Request channel interface: valid/ready handshake with the request payload.
`timescale 1ns / 1ps
`default_nettype none

interface ghsa_req_if;
   import ghsa_pkg::*;

   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [BYTES_W-1:0]  object_bytes;
   logic [HANDLE_W-1:0] handle;

   modport source (output valid, output kind, output object_bytes, output handle,
                   input ready);
   modport sink   (input valid, input kind, input object_bytes, input handle,
                   output ready);
endinterface

`default_nettype wire

// ===== design/ghsa_rsp_if.sv =====
// Response channel interface: valid/ready handshake with the result payload.
`timescale 1ns / 1ps
`default_nettype none

interface ghsa_rsp_if;
   import ghsa_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [HANDLE_W-1:0] result_handle;
   logic [LIVE_W-1:0]   live_count;
   logic [BYTES_W-1:0]  storage_used;

   modport source (output valid, output status, output result_handle,
                   output live_count, output storage_used, input ready);
   modport sink   (input valid, input status, input result_handle,
                   input live_count, input storage_used, output ready);
endinterface

`default_nettype wire

// ===== design/ghsa_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ghsa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                                clock,
   input  wire logic                                wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                    wr_data,
   input  wire logic                                rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                    rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, holds its data while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/generational_handle_slot_allocator.sv =====
// Generational handle slot allocator: slot table in RAM with live and byte budgets.
// Steps to the result register: a budget refusal or out-of-range handle finishes in its
//   check state, release/lookup finish in ST_LOOK_WR after the slot read, allocate scans
//   bitmap words from the hint (none if the table is empty), clear zeroes occupancy words.
// One item at a time: the next request is taken the cycle after the result is registered.
// The free-slot search reads one 32-slot bitmap word per cycle from the occupancy RAM.
// Synchronous reset clears control state only; the block is ready the cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module generational_handle_slot_allocator #(
   parameter int SLOT_COUNT = ghsa_pkg::SLOT_COUNT_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   ghsa_req_if.sink                          req_ch,
   ghsa_rsp_if.source                        rsp_ch,
   input  wire logic                         csr_wr_en,
   input  wire ghsa_pkg::csr_index_type      csr_index,
   input  wire logic [ghsa_pkg::CSR_W-1:0]   csr_wdata
);
   import ghsa_pkg::*;

   localparam int IDX_W      = $clog2(SLOT_COUNT);
   localparam int HWM_W      = $clog2(SLOT_COUNT + 1);
   localparam int WORD_COUNT = (SLOT_COUNT + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

   // Lowest set bit of a bitmap word
   function automatic logic [WORD_BIT_W-1:0] first_set(input logic [WORD_BITS-1:0] v);
      logic [WORD_BIT_W-1:0] pos;
      pos = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            pos = WORD_BIT_W'(i);
         end
      end
      return pos;
   endfunction

   // Control and bookkeeping registers
   state_type             state_ff, state_in;
   logic [LIVE_W-1:0]     max_live_ff;
   logic [BYTES_W-1:0]    max_bytes_ff;
   logic [HWM_W-1:0]      hwm_ff, hwm_in;
   logic [LIVE_W-1:0]     live_ff, live_in;
   logic [BYTES_W-1:0]    bytes_ff, bytes_in;
   logic [WORD_W-1:0]     hint_ff, hint_in;
   logic [WORD_W-1:0]     scan_ptr_ff, scan_ptr_in;
   logic [IDX_W-1:0]      tgt_ff, tgt_in;
   logic                  reuse_ff, reuse_in;

   // Captured request
   kind_type              kind_ff;
   logic [BYTES_W-1:0]    size_ff;
   logic [HANDLE_W-1:0]   handle_ff;

   // Result register
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff;
   logic [HANDLE_W-1:0]   rsp_handle_ff;
   logic [LIVE_W-1:0]     rsp_live_ff;
   logic [BYTES_W-1:0]    rsp_bytes_ff;

   // Result of the item that finishes this cycle
   status_type            res_status;
   logic [HANDLE_W-1:0]   res_handle;
   logic [LIVE_W-1:0]     res_live;
   logic [BYTES_W-1:0]    res_bytes;

   // RAM ports
   logic                  word_rd_en;
   logic [WORD_W-1:0]     word_rd_addr;
   logic [WORD_BITS-1:0]  occ_rd, ret_rd;
   logic                  occ_wr_en, ret_wr_en;
   logic [WORD_W-1:0]     occ_wr_addr;
   logic [WORD_BITS-1:0]  occ_wr_data, ret_wr_data;
   logic                  slot_rd_en;
   logic [GEN_W-1:0]      gen_rd;
   logic [BYTES_W-1:0]    bytes_rd;
   logic                  slot_wr_en;
   logic [GEN_W-1:0]      new_gen;

   // Decision signals
   logic                  req_accept;
   logic                  out_free;
   logic                  finish_req;
   logic                  do_finish;
   logic                  go_slot;

   // Derived values
   logic [31:0]           hwm32, last32, base32, rem32;
   logic [WORD_W-1:0]     last_word;
   logic                  hwm_zero, hwm_full, at_last;
   logic [WORD_BITS-1:0]  valid_mask, avail_bits, tff_onehot;
   logic                  found;
   logic [WORD_BIT_W-1:0] found_bit;
   logic [31:0]           found32;
   logic                  live_fail, bytes_fail;
   logic [BYTES_W:0]      sum_bytes;
   logic [31:0]           low32, idx32;
   logic                  range_ok;
   logic [31:0]           tin32, tin_word32, tff32, tff_word32;
   logic [WORD_W-1:0]     tin_word, tff_word;
   logic [WORD_BIT_W-1:0] tff_bit;
   logic                  slot_ok;
   logic                  is_release;

   // Handshakes
   assign req_accept = req_ch.valid && req_ch.ready;
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign do_finish  = finish_req && out_free;

   // High-water mark and scan window
   assign hwm32     = 32'(hwm_ff);
   assign last32    = (hwm32 - 32'd1) >> WORD_BIT_W;
   assign last_word = last32[WORD_W-1:0];
   assign hwm_zero  = (hwm_ff == '0);
   assign hwm_full  = (hwm_ff == HWM_W'(SLOT_COUNT));
   assign at_last   = (scan_ptr_ff == last_word);
   assign base32    = 32'(scan_ptr_ff) << WORD_BIT_W;
   assign rem32     = hwm32 - base32;

   // Free, non-retired slots below the high-water mark in the scanned word
   assign valid_mask = at_last ? ~({WORD_BITS{1'b1}} << rem32[WORD_BIT_W:0])
                               : {WORD_BITS{1'b1}};
   assign avail_bits = ~occ_rd & ~ret_rd & valid_mask;
   assign found      = |avail_bits;
   assign found_bit  = first_set(avail_bits);
   assign found32    = base32 | 32'(found_bit);

   // Budget checks, the byte sum carries one extra bit so it cannot wrap
   assign live_fail  = (live_ff >= max_live_ff);
   assign sum_bytes  = {1'b0, bytes_ff} + {1'b0, size_ff};
   assign bytes_fail = (sum_bytes > {1'b0, max_bytes_ff});

   // Handle range check
   assign low32    = handle_ff[31:0];
   assign idx32    = low32 - 32'd1;
   assign range_ok = (low32 != 32'd0) && (idx32 < hwm32);

   // Word and bit position of the target slot
   assign tin32      = 32'(tgt_in);
   assign tin_word32 = tin32 >> WORD_BIT_W;
   assign tin_word   = tin_word32[WORD_W-1:0];
   assign tff32      = 32'(tgt_ff);
   assign tff_word32 = tff32 >> WORD_BIT_W;
   assign tff_word   = tff_word32[WORD_W-1:0];
   assign tff_bit    = tff32[WORD_BIT_W-1:0];
   assign tff_onehot = WORD_BITS'(1) << tff_bit;

   assign new_gen    = reuse_ff ? (gen_rd + 32'd1) : '0;
   assign slot_ok    = occ_rd[tff_bit] && (gen_rd == handle_ff[63:32]);
   assign is_release = (kind_ff == KIND_RELEASE);

   // Finish condition and target slot selection
   always_comb begin
      finish_req = 1'b0;
      go_slot    = 1'b0;
      tgt_in     = tgt_ff;
      case (state_ff)
         ST_ALLOC_CHECK: begin
            finish_req = live_fail || bytes_fail;
            go_slot    = hwm_zero;
            tgt_in     = hwm32[IDX_W-1:0];
         end
         ST_SCAN_EVAL: begin
            finish_req = !found && at_last && hwm_full;
            go_slot    = found || (at_last && !hwm_full);
            tgt_in     = found ? found32[IDX_W-1:0] : hwm32[IDX_W-1:0];
         end
         ST_SLOT_WR: begin
            finish_req = 1'b1;
         end
         ST_LOOK_CHECK: begin
            finish_req = !range_ok;
            tgt_in     = idx32[IDX_W-1:0];
         end
         ST_LOOK_WR: begin
            finish_req = 1'b1;
         end
         ST_CLEAR: begin
            finish_req = hwm_zero || (scan_ptr_ff == last_word);
         end
         default: begin
            finish_req = 1'b0;
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (kind_type'(req_ch.kind))
                  KIND_ALLOC:   state_in = ST_ALLOC_CHECK;
                  KIND_RELEASE: state_in = ST_LOOK_CHECK;
                  KIND_LOOKUP:  state_in = ST_LOOK_CHECK;
                  KIND_CLEAR:   state_in = ST_CLEAR;
                  default:      state_in = ST_IDLE;
               endcase
            end
         end
         ST_ALLOC_CHECK: begin
            if (finish_req) begin
               state_in = out_free ? ST_IDLE : ST_ALLOC_CHECK;
            end else begin
               state_in = go_slot ? ST_SLOT_WR : ST_SCAN_EVAL;
            end
         end
         ST_SCAN_EVAL: begin
            if (finish_req) begin
               state_in = out_free ? ST_IDLE : ST_SCAN_EVAL;
            end else if (go_slot) begin
               state_in = ST_SLOT_WR;
            end
         end
         ST_SLOT_WR: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_LOOK_CHECK: begin
            if (finish_req) begin
               state_in = out_free ? ST_IDLE : ST_LOOK_CHECK;
            end else begin
               state_in = ST_LOOK_WR;
            end
         end
         ST_LOOK_WR: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            if (do_finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath, RAM control and result values
   always_comb begin
      hwm_in       = hwm_ff;
      live_in      = live_ff;
      bytes_in     = bytes_ff;
      hint_in      = hint_ff;
      scan_ptr_in  = scan_ptr_ff;
      reuse_in     = reuse_ff;
      res_status   = STATUS_OK;
      res_handle   = '0;
      res_live     = live_ff;
      res_bytes    = bytes_ff;
      word_rd_en   = 1'b0;
      word_rd_addr = tin_word;
      slot_rd_en   = 1'b0;
      occ_wr_en    = 1'b0;
      occ_wr_addr  = tff_word;
      occ_wr_data  = occ_rd | tff_onehot;
      ret_wr_en    = 1'b0;
      ret_wr_data  = (new_gen == GEN_MAX) ? (ret_rd | tff_onehot) : (ret_rd & ~tff_onehot);
      slot_wr_en   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            scan_ptr_in = (kind_type'(req_ch.kind) == KIND_CLEAR) ? '0 : hint_ff;
         end
         ST_ALLOC_CHECK: begin
            if (finish_req) begin
               res_status = live_fail ? STATUS_LIVE : STATUS_STORAGE;
            end else begin
               // Start the search at the hint word, or go straight to an append
               word_rd_en   = 1'b1;
               word_rd_addr = go_slot ? tin_word : scan_ptr_ff;
               slot_rd_en   = go_slot;
               reuse_in     = 1'b0;
            end
         end
         ST_SCAN_EVAL: begin
            hint_in = scan_ptr_ff;
            if (finish_req) begin
               res_status = STATUS_EXHAUSTED;
            end else if (go_slot) begin
               word_rd_en   = 1'b1;
               word_rd_addr = tin_word;
               slot_rd_en   = 1'b1;
               reuse_in     = found;
            end else begin
               scan_ptr_in  = scan_ptr_ff + WORD_W'(1);
               word_rd_en   = 1'b1;
               word_rd_addr = scan_ptr_ff + WORD_W'(1);
            end
         end
         ST_SLOT_WR: begin
            res_handle = {new_gen, tff32 + 32'd1};
            res_live   = live_ff + LIVE_W'(1);
            res_bytes  = bytes_ff + size_ff;
            if (out_free) begin
               occ_wr_en  = 1'b1;
               ret_wr_en  = 1'b1;
               slot_wr_en = 1'b1;
               hwm_in     = reuse_ff ? hwm_ff : (hwm_ff + HWM_W'(1));
               live_in    = res_live;
               bytes_in   = res_bytes;
            end
         end
         ST_LOOK_CHECK: begin
            if (finish_req) begin
               res_status = STATUS_STALE;
            end else begin
               word_rd_en = 1'b1;
               slot_rd_en = 1'b1;
            end
         end
         ST_LOOK_WR: begin
            if (!slot_ok) begin
               res_status = STATUS_STALE;
            end else begin
               res_handle = handle_ff;
               if (is_release) begin
                  res_live    = live_ff - LIVE_W'(1);
                  res_bytes   = bytes_ff - bytes_rd;
                  occ_wr_data = occ_rd & ~tff_onehot;
                  if (out_free) begin
                     occ_wr_en = 1'b1;
                     live_in   = res_live;
                     bytes_in  = res_bytes;
                     hint_in   = (tff_word < hint_ff) ? tff_word : hint_ff;
                  end
               end
            end
         end
         ST_CLEAR: begin
            // Zero one occupancy word per cycle up to the high-water mark
            occ_wr_en   = !hwm_zero;
            occ_wr_addr = scan_ptr_ff;
            occ_wr_data = '0;
            res_live    = '0;
            res_bytes   = '0;
            if (finish_req) begin
               if (out_free) begin
                  live_in  = '0;
                  bytes_in = '0;
                  hint_in  = '0;
               end
            end else begin
               scan_ptr_in = scan_ptr_ff + WORD_W'(1);
            end
         end
         default: begin
            res_status = STATUS_OK;
         end
      endcase
   end

   assign rsp_valid_in = do_finish || (rsp_valid_ff && !rsp_ch.ready);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         hwm_ff       <= '0;
         live_ff      <= '0;
         bytes_ff     <= '0;
         hint_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         hwm_ff       <= hwm_in;
         live_ff      <= live_in;
         bytes_ff     <= bytes_in;
         hint_ff      <= hint_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_live_ff  <= MAX_LIVE_RESET;
         max_bytes_ff <= MAX_BYTES_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MAX_LIVE:  max_live_ff  <= csr_wdata[LIVE_W-1:0];
            CSR_MAX_BYTES: max_bytes_ff <= csr_wdata[BYTES_W-1:0];
            default:       max_live_ff  <= max_live_ff;
         endcase
      end
   end

   // Working payload registers
   always_ff @(posedge clock) begin
      scan_ptr_ff <= scan_ptr_in;
      tgt_ff      <= tgt_in;
      reuse_ff    <= reuse_in;
      if (req_accept) begin
         kind_ff   <= kind_type'(req_ch.kind);
         size_ff   <= req_ch.object_bytes;
         handle_ff <= req_ch.handle;
      end
   end

   // Result payload register
   always_ff @(posedge clock) begin
      if (do_finish) begin
         rsp_status_ff <= res_status;
         rsp_handle_ff <= res_handle;
         rsp_live_ff   <= res_live;
         rsp_bytes_ff  <= res_bytes;
      end
   end

   // Occupancy bitmap, one bit per slot
   ghsa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (WORD_COUNT)
   ) u_occ_ram (
      .clock   (clock),
      .wr_en   (occ_wr_en),
      .wr_addr (occ_wr_addr),
      .wr_data (occ_wr_data),
      .rd_en   (word_rd_en),
      .rd_addr (word_rd_addr),
      .rd_data (occ_rd)
   );

   // Retirement bitmap, set when a slot's generation reaches its maximum
   ghsa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (WORD_COUNT)
   ) u_ret_ram (
      .clock   (clock),
      .wr_en   (ret_wr_en),
      .wr_addr (tff_word),
      .wr_data (ret_wr_data),
      .rd_en   (word_rd_en),
      .rd_addr (word_rd_addr),
      .rd_data (ret_rd)
   );

   // Per-slot generation counters
   ghsa_ram #(
      .WIDTH (GEN_W),
      .DEPTH (SLOT_COUNT)
   ) u_gen_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (tgt_ff),
      .wr_data (new_gen),
      .rd_en   (slot_rd_en),
      .rd_addr (tgt_in),
      .rd_data (gen_rd)
   );

   // Per-slot accounted byte sizes
   ghsa_ram #(
      .WIDTH (BYTES_W),
      .DEPTH (SLOT_COUNT)
   ) u_bytes_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (tgt_ff),
      .wr_data (size_ff),
      .rd_en   (slot_rd_en),
      .rd_addr (tgt_in),
      .rd_data (bytes_rd)
   );

   // Channel outputs
   assign req_ch.ready         = (state_ff == ST_IDLE);
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.result_handle = rsp_handle_ff;
   assign rsp_ch.live_count    = rsp_live_ff;
   assign rsp_ch.storage_used  = rsp_bytes_ff;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the generational handle slot allocator.
`timescale 1ns / 1ps

module tb_top;
   import ghsa_pkg::*;

   localparam int SLOT_N = SLOT_COUNT_DEFAULT;

   // How the driver fills in the handle of a release or lookup
   typedef enum logic [2:0] {
      PICK_RAW,
      PICK_LIVE,
      PICK_STALE_GEN,
      PICK_FREED,
      PICK_ABOVE_MARK
   } handle_pick_type;

   typedef struct packed {
      bit                  is_csr;
      csr_index_type       csr_sel;
      logic [CSR_W-1:0]    csr_val;
      kind_type            kind;
      logic [BYTES_W-1:0]  nbytes;
      logic [HANDLE_W-1:0] handle;
      handle_pick_type     pick;
      bit                  may_idle;
   } stim_item_type;

   typedef struct packed {
      status_type          status;
      logic [HANDLE_W-1:0] handle;
      logic [LIVE_W-1:0]   live;
      logic [BYTES_W-1:0]  used;
   } slot_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // Values driven into the block
   logic                req_valid  = 1'b0;
   kind_type            req_kind   = KIND_ALLOC;
   logic [BYTES_W-1:0]  req_bytes  = '0;
   logic [HANDLE_W-1:0] req_handle = '0;
   logic                rsp_ready  = 1'b0;
   logic                csr_wr_en  = 1'b0;
   csr_index_type       csr_sel_q  = CSR_MAX_LIVE;
   logic [CSR_W-1:0]    csr_data_q = '0;

   ghsa_req_if req_bus ();
   ghsa_rsp_if rsp_bus ();

   assign req_bus.valid        = req_valid;
   assign req_bus.kind         = req_kind;
   assign req_bus.object_bytes = req_bytes;
   assign req_bus.handle       = req_handle;
   assign rsp_bus.ready        = rsp_ready;

   generational_handle_slot_allocator #(
      .SLOT_COUNT(SLOT_N)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_sel_q),
      .csr_wdata (csr_data_q)
   );

   // Shadow copy of the slot table, totals and budgets
   bit                 slot_live [SLOT_N];
   logic [GEN_W-1:0]   slot_gen  [SLOT_N];
   logic [BYTES_W-1:0] slot_size [SLOT_N];
   int                 high_water;
   logic [LIVE_W-1:0]  live_now;
   logic [BYTES_W-1:0] used_now;
   logic [LIVE_W-1:0]  live_cap;
   logic [BYTES_W-1:0] byte_cap;

   stim_item_type  op_backlog[$];
   slot_reply_type pending_replies[$];

   // Driver state
   bit                  offering = 1'b0;
   int                  gap_left = 0;
   int                  csr_settle = 4;
   kind_type            shown_kind;
   logic [BYTES_W-1:0]  shown_bytes;
   logic [HANDLE_W-1:0] shown_handle;
   bit                  fill_may_idle = 1'b1;

   // Receiver state
   bit stall_allowed = 1'b1;
   bit long_hold     = 1'b0;
   bit calm_stretch  = 1'b0;
   int calm_left     = 0;
   int hold_left     = 0;
   int replies_seen  = 0;
   int reply_errors  = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // Applies one transaction to the shadow table and returns the reply it should give
   function automatic slot_reply_type predict_slot_op(kind_type k, logic [BYTES_W-1:0] nbytes,
                                                      logic [HANDLE_W-1:0] h);
      slot_reply_type    r;
      int                spot;
      logic [BYTES_W:0]  room;
      logic [31:0]       low;
      logic [31:0]       tag;
      r.status = STATUS_OK;
      r.handle = '0;
      spot = -1;
      case (k)
         KIND_ALLOC: begin
            room = {1'b0, used_now} + {1'b0, nbytes};
            if (live_now >= live_cap) begin
               r.status = STATUS_LIVE;
            end else if (room > {1'b0, byte_cap}) begin
               r.status = STATUS_STORAGE;
            end else begin
               // lowest free slot that is not retired, else append
               for (int i = 0; i < high_water; i++)
                  if (spot < 0 && !slot_live[i] && slot_gen[i] != GEN_MAX) spot = i;
               if (spot >= 0) begin
                  slot_gen[spot] = slot_gen[spot] + 1'b1;
               end else if (high_water < SLOT_N) begin
                  spot = high_water;
                  high_water++;
               end else begin
                  r.status = STATUS_EXHAUSTED;
               end
               if (spot >= 0) begin
                  slot_live[spot] = 1'b1;
                  slot_size[spot] = nbytes;
                  live_now = live_now + 1'b1;
                  used_now = used_now + nbytes;
                  tag = spot + 1;
                  r.handle = {slot_gen[spot], tag};
               end
            end
         end
         KIND_RELEASE, KIND_LOOKUP: begin
            // valid: low word names a slot below the mark, occupied, same generation
            low = h[31:0];
            if (low != 0 && low <= high_water)
               if (slot_live[low - 1] && slot_gen[low - 1] == h[63:32]) spot = low - 1;
            if (spot < 0) begin
               r.status = STATUS_STALE;
            end else begin
               r.handle = h;
               if (k == KIND_RELEASE) begin
                  used_now = used_now - slot_size[spot];
                  slot_live[spot] = 1'b0;
                  live_now = live_now - 1'b1;
               end
            end
         end
         default: begin
            // clear keeps generations and the high-water mark
            for (int i = 0; i < SLOT_N; i++) slot_live[i] = 1'b0;
            live_now = '0;
            used_now = '0;
         end
      endcase
      r.live = live_now;
      r.used = used_now;
      return r;
   endfunction

   // Builds a concrete handle from the current shadow table
   function automatic logic [HANDLE_W-1:0] pick_handle(handle_pick_type how,
                                                       logic [HANDLE_W-1:0] raw);
      logic [HANDLE_W-1:0] h;
      logic [31:0]         tag;
      bit                  need_live;
      int                  hits;
      int                  want;
      int                  chosen;
      h = raw;
      hits = 0;
      chosen = -1;
      need_live = (how != PICK_FREED);
      for (int i = 0; i < high_water; i++)
         if (slot_live[i] == need_live) hits++;
      want = (hits > 0) ? $urandom_range(0, hits - 1) : 0;
      for (int i = 0; i < high_water; i++)
         if (slot_live[i] == need_live) begin
            if (want == 0) chosen = i;
            want--;
         end
      tag = chosen + 1;
      case (how)
         PICK_LIVE, PICK_FREED: begin
            if (chosen >= 0) h = {slot_gen[chosen], tag};
         end
         PICK_STALE_GEN: begin
            if (chosen >= 0)
               h = {slot_gen[chosen] ^ (32'd1 << $urandom_range(0, 31)), tag};
         end
         PICK_ABOVE_MARK: begin
            tag = high_water + 1 + $urandom_range(0, 40);
            h = {raw[63:32], tag};
         end
         default: ;
      endcase
      return h;
   endfunction

   function automatic void queue_op(kind_type k, logic [BYTES_W-1:0] nbytes,
                                    logic [HANDLE_W-1:0] h, handle_pick_type how);
      stim_item_type s;
      s = '0;
      s.kind = k;
      s.nbytes = nbytes;
      s.handle = h;
      s.pick = how;
      s.may_idle = fill_may_idle;
      op_backlog = {op_backlog, s};
   endfunction

   function automatic void queue_csr(csr_index_type sel, logic [CSR_W-1:0] val);
      stim_item_type s;
      s = '0;
      s.is_csr = 1'b1;
      s.csr_sel = sel;
      s.csr_val = val;
      op_backlog = {op_backlog, s};
   endfunction

   // Mostly small objects, now and then a full-width size
   function automatic logic [BYTES_W-1:0] random_size();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 7) return $urandom_range(0, 4096);
      if (roll < 9) return $urandom_range(0, 1 << 24);
      return $urandom;
   endfunction

   // Request driver: offers backlog items, writes registers only when drained
   always @(posedge clock) begin : driver
      bit            keep;
      bit            wr;
      stim_item_type nxt;
      keep = offering;
      wr = 1'b0;
      if (reset) begin
         for (int i = 0; i < SLOT_N; i++) begin
            slot_live[i] = 1'b0;
            slot_gen[i]  = '0;
            slot_size[i] = '0;
         end
         high_water = 0;
         live_now   = '0;
         used_now   = '0;
         live_cap   = MAX_LIVE_RESET;
         byte_cap   = MAX_BYTES_RESET;
         offering   = 1'b0;
         gap_left   = 0;
         csr_settle = 4;
         req_valid <= 1'b0;
         csr_wr_en <= 1'b0;
      end else begin
         // transaction accepted: predict its reply
         if (offering && req_bus.ready) begin
            pending_replies = {pending_replies,
                               predict_slot_op(shown_kind, shown_bytes, shown_handle)};
            keep = 1'b0;
         end
         if (!keep && op_backlog.size() != 0) begin
            if (op_backlog[0].is_csr) begin
               if (pending_replies.size() != 0) begin
                  csr_settle = 4;
               end else if (csr_settle != 0) begin
                  csr_settle--;
               end else begin
                  nxt = op_backlog.pop_front();
                  if (nxt.csr_sel == CSR_MAX_LIVE) live_cap = nxt.csr_val[LIVE_W-1:0];
                  else byte_cap = nxt.csr_val;
                  csr_sel_q  <= nxt.csr_sel;
                  csr_data_q <= nxt.csr_val;
                  wr = 1'b1;
                  csr_settle = 4;
               end
            end else if (gap_left != 0) begin
               gap_left--;
            end else if (op_backlog[0].may_idle && $urandom_range(0, 7) == 0) begin
               gap_left = $urandom_range(0, 13);
            end else begin
               nxt = op_backlog.pop_front();
               shown_kind   = nxt.kind;
               shown_bytes  = nxt.nbytes;
               shown_handle = pick_handle(nxt.pick, nxt.handle);
               req_kind   <= shown_kind;
               req_bytes  <= shown_bytes;
               req_handle <= shown_handle;
               stall_allowed <= nxt.may_idle;
               keep = 1'b1;
            end
         end
         offering = keep;
         req_valid <= keep;
         csr_wr_en <= wr;
      end
   end

   // Reply monitor and receiver stalls
   always @(posedge clock) begin : monitor
      slot_reply_type want;
      bit             have;
      if (reset) begin
         hold_left = 0;
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_ready) begin
            have = (pending_replies.size() != 0);
            want = 'x;
            if (have) want = pending_replies.pop_front();
            replies_seen++;
            if (!have || rsp_bus.status !== want.status
                || rsp_bus.result_handle !== want.handle
                || rsp_bus.live_count !== want.live
                || rsp_bus.storage_used !== want.used) begin
               if (reply_errors < 10)
                  $display("reply %0d mismatch: expected status %0d handle %h live %0d used %h,",
                           replies_seen, want.status, want.handle, want.live, want.used,
                           " got status %0d handle %h live %0d used %h",
                           rsp_bus.status, rsp_bus.result_handle, rsp_bus.live_count,
                           rsp_bus.storage_used);
               reply_errors++;
            end
         end
         // stretches with and without stalls
         if (calm_left == 0) begin
            calm_stretch = ($urandom_range(0, 3) == 0);
            calm_left = $urandom_range(20, 120);
         end else begin
            calm_left--;
         end
         if (long_hold) begin
            rsp_ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_allowed && !calm_stretch && $urandom_range(0, 7) == 0) begin
            hold_left = $urandom_range(0, 13);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Long receiver hold-off while the allocator is busy filling its table
   initial begin
      wait (replies_seen >= 150);
      @(posedge clock);
      long_hold <= 1'b1;
      repeat (300) @(posedge clock);
      long_hold <= 1'b0;
   end

   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // Stimulus and end of run
   initial begin
      int                  roll;
      logic [HANDLE_W-1:0] raw;
      handle_pick_type     how;
      logic [CSR_W-1:0]    live_val;
      logic [CSR_W-1:0]    bytes_val;

      // directed: null and malformed handles, byte budget edge, reuse, clear
      queue_op(KIND_LOOKUP, 32'h0, 64'h0, PICK_RAW);
      queue_op(KIND_RELEASE, 32'hFFFF_FFFF, 64'h0, PICK_RAW);
      queue_op(KIND_ALLOC, 32'h0, 64'h0, PICK_RAW);
      queue_op(KIND_ALLOC, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, PICK_RAW);
      queue_op(KIND_ALLOC, 32'h1, 64'h0, PICK_RAW);
      queue_op(KIND_LOOKUP, 32'h0, 64'h0, PICK_LIVE);
      queue_op(KIND_LOOKUP, 32'h0, 64'hFFFF_FFFF_0000_0000, PICK_RAW);
      queue_op(KIND_LOOKUP, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, PICK_RAW);
      queue_op(KIND_LOOKUP, 32'h0, 64'h0, PICK_ABOVE_MARK);
      queue_op(KIND_LOOKUP, 32'h0, 64'h0, PICK_STALE_GEN);
      queue_op(KIND_RELEASE, 32'h0, 64'h2, PICK_RAW);
      queue_op(KIND_RELEASE, 32'h0, 64'h2, PICK_RAW);
      queue_op(KIND_LOOKUP, 32'h0, 64'h0, PICK_FREED);
      queue_op(KIND_ALLOC, 32'h10, 64'h0, PICK_RAW);
      queue_op(KIND_LOOKUP, 32'h0, 64'h2, PICK_RAW);
      queue_op(KIND_ALLOC, 32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, PICK_RAW);
      queue_op(KIND_RELEASE, 32'h0, 64'h0, PICK_LIVE);
      queue_op(KIND_CLEAR, 32'hAAAA_AAAA, 64'h5555_5555_5555_5555, PICK_RAW);
      queue_op(KIND_LOOKUP, 32'h0, 64'h1, PICK_RAW);
      queue_op(KIND_ALLOC, 32'h7, 64'h0, PICK_RAW);
      // budgets lowered below current use
      queue_csr(CSR_MAX_LIVE, 32'd0);
      queue_op(KIND_ALLOC, 32'hFFFF_FFFF, 64'h0, PICK_RAW);
      queue_csr(CSR_MAX_BYTES, 32'd0);
      queue_csr(CSR_MAX_LIVE, 32'd2);
      queue_op(KIND_ALLOC, 32'h0, 64'h0, PICK_RAW);
      queue_op(KIND_RELEASE, 32'h0, 64'h0, PICK_LIVE);
      queue_op(KIND_ALLOC, 32'h0, 64'h0, PICK_RAW);
      queue_op(KIND_ALLOC, 32'h1, 64'h0, PICK_RAW);
      queue_csr(CSR_MAX_LIVE, 32'(MAX_LIVE_RESET));
      queue_csr(CSR_MAX_BYTES, MAX_BYTES_RESET);
      queue_op(KIND_CLEAR, 32'h0, 64'h0, PICK_RAW);

      // fill the whole table past its end with a live budget above the slot count
      queue_csr(CSR_MAX_LIVE, 32'h1FF);
      for (int n = 0; n < 262; n++) begin
         if (n % 30 == 0) fill_may_idle = ($urandom_range(0, 3) != 0);
         queue_op(KIND_ALLOC, $urandom_range(0, 1000), {$urandom, $urandom}, PICK_RAW);
      end
      for (int n = 0; n < 3; n++) queue_op(KIND_LOOKUP, $urandom, {$urandom, $urandom},
                                           PICK_ABOVE_MARK);
      for (int n = 0; n < 5; n++) queue_op(KIND_RELEASE, $urandom, 64'h0, PICK_LIVE);
      for (int n = 0; n < 7; n++) queue_op(KIND_ALLOC, $urandom_range(0, 1000), 64'h0,
                                           PICK_RAW);
      queue_csr(CSR_MAX_LIVE, 32'(MAX_LIVE_RESET));
      queue_op(KIND_ALLOC, 32'h0, 64'h0, PICK_RAW);
      queue_op(KIND_ALLOC, 32'h0, 64'h0, PICK_RAW);
      queue_op(KIND_CLEAR, 32'h0, 64'h0, PICK_RAW);

      // random phases, each under its own budgets
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin live_val = $urandom_range(1, 8);   bytes_val = 32'hFFFF_FFFF; end
            1: begin live_val = 256; bytes_val = $urandom_range(0, 1 << 16); end
            2: begin live_val = $urandom_range(0, 256); bytes_val = $urandom; end
            3: begin live_val = 32'h1FF; bytes_val = $urandom_range(1 << 20, 1 << 28); end
            default: begin live_val = 256;              bytes_val = 32'hFFFF_FFFF; end
         endcase
         queue_csr(CSR_MAX_LIVE, live_val);
         queue_csr(CSR_MAX_BYTES, bytes_val);
         for (int n = 0; n < 90; n++) begin
            if (n % 30 == 0) fill_may_idle = ($urandom_range(0, 3) != 0);
            if (ph == 4 && n >= 10) fill_may_idle = 1'b0;
            roll = $urandom_range(0, 99);
            raw = {$urandom, $urandom};
            if (roll < 42) begin
               queue_op(KIND_ALLOC, random_size(), raw, PICK_RAW);
            end else if (roll < 66) begin
               queue_op(KIND_RELEASE, $urandom, raw, (roll < 61) ? PICK_LIVE : PICK_STALE_GEN);
            end else if (roll < 96) begin
               if (roll < 80) how = PICK_LIVE;
               else if (roll < 85) how = PICK_STALE_GEN;
               else if (roll < 89) how = PICK_FREED;
               else if (roll < 93) how = PICK_ABOVE_MARK;
               else how = PICK_RAW;
               queue_op(KIND_LOOKUP, $urandom, raw, how);
            end else begin
               queue_op(KIND_CLEAR, $urandom, raw, PICK_RAW);
            end
         end
      end

      // drain, then let the block settle
      @(posedge clock);
      while (op_backlog.size() != 0 || offering || pending_replies.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (reply_errors == 0 && pending_replies.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
